// ----- design/cvms_pkg.sv -----
package cvms_pkg;

   localparam int MAX_MODES   = 256;
   localparam int POS_W       = $clog2(MAX_MODES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int ADDR_W = 5;

   localparam logic [2:0] REG_WANT_RED    = 3'd0;
   localparam logic [2:0] REG_WANT_GREEN  = 3'd1;
   localparam logic [2:0] REG_WANT_BLUE   = 3'd2;
   localparam logic [2:0] REG_WANT_WIDTH  = 3'd3;
   localparam logic [2:0] REG_WANT_HEIGHT = 3'd4;
   localparam logic [2:0] REG_WANT_RATE   = 3'd5;
   localparam logic [2:0] REG_IGNORE_MASK = 3'd6;

   localparam int IGN_RED   = 0;
   localparam int IGN_GREEN = 1;
   localparam int IGN_BLUE  = 2;
   localparam int IGN_RATE  = 3;

   typedef struct packed {
      logic [4:0]  red;
      logic [4:0]  green;
      logic [4:0]  blue;
      logic [13:0] width;
      logic [13:0] height;
      logic [9:0]  rate;
   } mode_type;

   typedef struct packed {
      logic [4:0]  want_red;
      logic [4:0]  want_green;
      logic [4:0]  want_blue;
      logic [13:0] want_width;
      logic [13:0] want_height;
      logic [9:0]  want_rate;
      logic [3:0]  ignore_mask;
   } cfg_type;

   // rate_key orders like the 32-bit rate distance: msb set for the
   // don't-care form, whose low bits are the inverted rate
   typedef struct packed {
      mode_type         mode;
      logic             last;
      logic             active;
      logic [POS_W-1:0] pos;
      logic [6:0]       color_gap;
      logic [28:0]      size_gap;
      logic [10:0]      rate_key;
   } entry_type;

   typedef struct packed {
      logic [7:0] index;
      mode_type   mode;
   } result_type;

endpackage

// ----- design/cvms_front.sv -----
module cvms_front (
   input  logic                clock,
   input  logic                reset,
   input  cvms_pkg::cfg_type   cfg,
   input  logic                req_push,
   input  cvms_pkg::mode_type  req_mode,
   input  logic                req_last,
   input  logic                q_full,
   output logic                q_push,
   output cvms_pkg::entry_type q_data
);

   function automatic logic [13:0] abs_diff(input logic [13:0] a, input logic [13:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [cvms_pkg::POS_W-1:0] pos_ff, pos_in;
   logic        active;
   logic [13:0] d_red, d_green, d_blue, d_rate, d_w, d_h;
   logic [4:0]  g_red, g_green, g_blue;
   logic [27:0] sq_w, sq_h;

   assign q_push = req_push & ~q_full;
   assign active = (pos_ff < cvms_pkg::POS_W'(cvms_pkg::MAX_MODES));

   always_comb begin
      d_red   = abs_diff({9'd0, req_mode.red},   {9'd0, cfg.want_red});
      d_green = abs_diff({9'd0, req_mode.green}, {9'd0, cfg.want_green});
      d_blue  = abs_diff({9'd0, req_mode.blue},  {9'd0, cfg.want_blue});
      d_rate  = abs_diff({4'd0, req_mode.rate},  {4'd0, cfg.want_rate});
      d_w     = abs_diff(req_mode.width,  cfg.want_width);
      d_h     = abs_diff(req_mode.height, cfg.want_height);
      g_red   = cfg.ignore_mask[cvms_pkg::IGN_RED]   ? 5'd0 : d_red[4:0];
      g_green = cfg.ignore_mask[cvms_pkg::IGN_GREEN] ? 5'd0 : d_green[4:0];
      g_blue  = cfg.ignore_mask[cvms_pkg::IGN_BLUE]  ? 5'd0 : d_blue[4:0];
      sq_w    = {14'd0, d_w} * {14'd0, d_w};
      sq_h    = {14'd0, d_h} * {14'd0, d_h};

      q_data.mode      = req_mode;
      q_data.last      = req_last;
      q_data.active    = active;
      q_data.pos       = pos_ff;
      q_data.color_gap = {2'd0, g_red} + {2'd0, g_green} + {2'd0, g_blue};
      q_data.size_gap  = {1'b0, sq_w} + {1'b0, sq_h};
      if (cfg.ignore_mask[cvms_pkg::IGN_RATE]) begin
         q_data.rate_key = {1'b1, ~req_mode.rate};
      end else begin
         q_data.rate_key = {1'b0, d_rate[9:0]};
      end
   end

   // position saturates once the list runs past the mode limit
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (req_last) begin
            pos_in = '0;
         end else if (active) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- design/cvms_queue.sv -----
module cvms_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cvms_pkg::entry_type wdata,
   output logic                full,
   input  logic                pop,
   output cvms_pkg::entry_type rdata,
   output logic                empty
);

   cvms_pkg::entry_type mem_ff [cvms_pkg::QUEUE_DEPTH];

   logic [cvms_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [cvms_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == cvms_pkg::QCNT_W'(cvms_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == cvms_pkg::QPTR_W'(cvms_pkg::QUEUE_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == cvms_pkg::QPTR_W'(cvms_pkg::QUEUE_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ----- design/cvms_back.sv -----
module cvms_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  cvms_pkg::entry_type  q_data,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output cvms_pkg::result_type rsp_data
);

   logic                       have_ff, have_in;
   logic                       out_valid_ff, out_valid_in;
   logic [6:0]                 least_color_ff;
   logic [28:0]                least_size_ff;
   logic [10:0]                least_rate_ff;
   logic [cvms_pkg::POS_W-1:0] chosen_pos_ff;
   cvms_pkg::mode_type         chosen_mode_ff;
   cvms_pkg::result_type       out_ff;
   logic better, out_free;

   assign out_free  = ~out_valid_ff | rsp_pop;
   assign q_pop     = ~q_empty & (~q_data.last | out_free);
   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   // strict compare keeps the earliest mode on a tie
   always_comb begin
      better = q_data.active &&
               (!have_ff ||
                (q_data.color_gap < least_color_ff) ||
                (q_data.color_gap == least_color_ff && q_data.size_gap < least_size_ff) ||
                (q_data.color_gap == least_color_ff && q_data.size_gap == least_size_ff &&
                 q_data.rate_key < least_rate_ff));
   end

   always_comb begin
      have_in      = have_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (q_pop) begin
         if (q_data.last) begin
            have_in      = 1'b0;
            out_valid_in = 1'b1;
         end else if (better) begin
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_ff      <= have_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && better) begin
         least_color_ff <= q_data.color_gap;
         least_size_ff  <= q_data.size_gap;
         least_rate_ff  <= q_data.rate_key;
         chosen_pos_ff  <= q_data.pos;
         chosen_mode_ff <= q_data.mode;
      end
      if (q_pop && q_data.last) begin
         if (better) begin
            out_ff.index <= 8'(q_data.pos);
            out_ff.mode  <= q_data.mode;
         end else begin
            out_ff.index <= 8'(chosen_pos_ff);
            out_ff.mode  <= chosen_mode_ff;
         end
      end
   end

endmodule

// ----- design/closest_video_mode_select_top.sv -----
// result: a mode marked last passes through the queue and then the result register
// throughput: one mode per cycle unless the queue is full or a last mode waits on the
// result register; the back-end running-best compare and front scoring are combinational
// reset: synchronous, clears the search, the queue and the result register;
// configuration returns to red/green/blue 8, size 0x0, rate 60, no ignores
module closest_video_mode_select_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [4:0]                  req_red_bits,
   input  logic [4:0]                  req_green_bits,
   input  logic [4:0]                  req_blue_bits,
   input  logic [13:0]                 req_mode_width,
   input  logic [13:0]                 req_mode_height,
   input  logic [9:0]                  req_refresh_rate,
   input  logic                        req_last_mode,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [7:0]                  rsp_best_index,
   output logic [4:0]                  rsp_best_red,
   output logic [4:0]                  rsp_best_green,
   output logic [4:0]                  rsp_best_blue,
   output logic [13:0]                 rsp_best_width,
   output logic [13:0]                 rsp_best_height,
   output logic [9:0]                  rsp_best_rate,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cvms_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   cvms_pkg::cfg_type    cfg_ff, cfg_in;
   cvms_pkg::mode_type   req_mode;
   cvms_pkg::entry_type  f_data, q_rdata;
   cvms_pkg::result_type rsp_data;
   logic       f_push, q_full, q_empty, q_pop, csr_wr;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            cvms_pkg::REG_WANT_RED:    cfg_in.want_red    = csr_pwdata[4:0];
            cvms_pkg::REG_WANT_GREEN:  cfg_in.want_green  = csr_pwdata[4:0];
            cvms_pkg::REG_WANT_BLUE:   cfg_in.want_blue   = csr_pwdata[4:0];
            cvms_pkg::REG_WANT_WIDTH:  cfg_in.want_width  = csr_pwdata[13:0];
            cvms_pkg::REG_WANT_HEIGHT: cfg_in.want_height = csr_pwdata[13:0];
            cvms_pkg::REG_WANT_RATE:   cfg_in.want_rate   = csr_pwdata[9:0];
            cvms_pkg::REG_IGNORE_MASK: cfg_in.ignore_mask = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         cvms_pkg::REG_WANT_RED:    csr_prdata = {27'd0, cfg_ff.want_red};
         cvms_pkg::REG_WANT_GREEN:  csr_prdata = {27'd0, cfg_ff.want_green};
         cvms_pkg::REG_WANT_BLUE:   csr_prdata = {27'd0, cfg_ff.want_blue};
         cvms_pkg::REG_WANT_WIDTH:  csr_prdata = {18'd0, cfg_ff.want_width};
         cvms_pkg::REG_WANT_HEIGHT: csr_prdata = {18'd0, cfg_ff.want_height};
         cvms_pkg::REG_WANT_RATE:   csr_prdata = {22'd0, cfg_ff.want_rate};
         cvms_pkg::REG_IGNORE_MASK: csr_prdata = {28'd0, cfg_ff.ignore_mask};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.want_red    <= 5'd8;
         cfg_ff.want_green  <= 5'd8;
         cfg_ff.want_blue   <= 5'd8;
         cfg_ff.want_width  <= 14'd0;
         cfg_ff.want_height <= 14'd0;
         cfg_ff.want_rate   <= 10'd60;
         cfg_ff.ignore_mask <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_mode.red    = req_red_bits;
      req_mode.green  = req_green_bits;
      req_mode.blue   = req_blue_bits;
      req_mode.width  = req_mode_width;
      req_mode.height = req_mode_height;
      req_mode.rate   = req_refresh_rate;
   end

   assign req_full = q_full;

   cvms_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_mode (req_mode),
      .req_last (req_last_mode),
      .q_full   (q_full),
      .q_push   (f_push),
      .q_data   (f_data)
   );

   cvms_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (f_data),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   cvms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_best_index  = rsp_data.index;
   assign rsp_best_red    = rsp_data.mode.red;
   assign rsp_best_green  = rsp_data.mode.green;
   assign rsp_best_blue   = rsp_data.mode.blue;
   assign rsp_best_width  = rsp_data.mode.width;
   assign rsp_best_height = rsp_data.mode.height;
   assign rsp_best_rate   = rsp_data.mode.rate;

endmodule
